>>> rtl/count_ordered_self_organizing_list_defines.svh
// Assertion macros used by the checker file of the list block.
`ifndef COUNT_ORDERED_SELF_ORGANIZING_LIST_DEFINES_SVH
`define COUNT_ORDERED_SELF_ORGANIZING_LIST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define COSL_CHECK_NOW(name, clk, rst, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("list check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define COSL_CHECK_NEXT(name, clk, rst, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("list check failed one cycle later");

`endif

>>> rtl/cosl_pkg.sv
`default_nettype none

package cosl_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int ACC_W   = 16;
  localparam int ENT_W   = 5;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_FIND = 2'd1;
  localparam op_t OP_POP  = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_MISS  = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_EMPTY = 2'd3;

endpackage

`default_nettype wire

>>> rtl/count_ordered_self_organizing_list.sv
// Ordered list of up to DEPTH signed values, each with a saturating access count,
// held in one simple dual-port memory (one read and one write per cycle, registered
// read). One beat in gives one beat out. A push writes the new entry at the back. A pop
// takes the front entry and moves the rest one place toward the front. A find has
// the memory port walk the list once to locate the value, once more to find where
// it belongs, and then move the entries in between one per cycle. A new beat is
// taken while the previous result still waits in the output register.
`default_nettype none

module count_ordered_self_organizing_list
  import cosl_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  op_t                       operation,
  input  logic signed [VALUE_W-1:0] item_value,
  output logic                      result_valid,
  input  logic                      result_ready,
  output status_t                   status,
  output logic [POS_W-1:0]          old_position,
  output logic [POS_W-1:0]          new_position,
  output logic [ACC_W-1:0]          access_count,
  output logic signed [VALUE_W-1:0] popped_value,
  output logic [ENT_W-1:0]          entry_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = VALUE_W + COUNT_BITS;

  typedef logic [IW-1:0]         idx_t;
  typedef logic [CW-1:0]         num_t;
  typedef logic [COUNT_BITS-1:0] acc_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RANK, S_MOVE, S_PUT, S_POPQ, S_EMIT
  } state_t;

  state_t state;
  num_t   used_entries;
  op_t    op_r;
  logic [VALUE_W-1:0] val_r;

  idx_t rd_ptr;
  num_t rd_left;
  logic q_vld;
  idx_t q_idx;
  idx_t wr_ptr;
  logic mv_dn;
  idx_t at_r;
  idx_t j_r;
  acc_t cnt_r;

  status_t            res_status;
  idx_t               res_old;
  idx_t               res_new;
  acc_t               res_cnt;
  logic [VALUE_W-1:0] res_pop;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] mem_q;

  logic          we;
  idx_t          waddr;
  logic [WW-1:0] wdata;

  logic [VALUE_W-1:0] q_value;
  acc_t               q_count;
  acc_t               q_count_inc;
  logic               q_last;
  logic               rank_take;
  idx_t               rank_j;
  idx_t               rd_ptr_inc;
  idx_t               rd_ptr_dec;

  assign item_ready  = (state == S_IDLE);
  assign q_value     = mem_q[WW-1:COUNT_BITS];
  assign q_count     = mem_q[COUNT_BITS-1:0];
  assign q_count_inc = (&q_count) ? q_count : q_count + acc_t'(1);
  assign q_last      = (num_t'(q_idx) == used_entries - num_t'(1));
  assign rd_ptr_inc  = rd_ptr + idx_t'(1);
  assign rd_ptr_dec  = rd_ptr - idx_t'(1);

  // Slot for the promoted entry, counted in the list with the entry taken out.
  assign rank_take = q_vld && (q_idx != at_r) && (q_count <= cnt_r);
  assign rank_j    = rank_take ? ((q_idx < at_r) ? q_idx : q_idx - idx_t'(1))
                               : idx_t'(used_entries - num_t'(1));

  always_comb begin
    we    = 1'b0;
    waddr = wr_ptr;
    wdata = mem_q;
    unique case (state)
      S_IDLE: begin
        if (item_valid && operation == OP_PUSH && used_entries < num_t'(DEPTH)) begin
          we    = 1'b1;
          waddr = idx_t'(used_entries);
          wdata = {item_value, {COUNT_BITS{1'b0}}};
        end
      end
      S_MOVE: begin
        we = q_vld;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = j_r;
        wdata = {val_r, cnt_r};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used_entries <= '0;
      rd_ptr       <= '0;
      q_vld        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          // rd_ptr rests at zero here, so the front entry is read on every accept.
          if (item_valid) begin
            op_r       <= operation;
            val_r      <= item_value;
            res_status <= ST_OK;
            res_old    <= '0;
            res_new    <= '0;
            res_cnt    <= '0;
            res_pop    <= '0;
            state      <= S_EMIT;
            unique case (operation)
              OP_PUSH: begin
                if (used_entries >= num_t'(DEPTH)) begin
                  res_status <= ST_FULL;
                end else begin
                  res_new      <= idx_t'(used_entries);
                  used_entries <= used_entries + num_t'(1);
                end
              end
              OP_FIND: begin
                if (used_entries == '0) begin
                  res_status <= ST_MISS;
                end else begin
                  q_vld   <= 1'b1;
                  q_idx   <= '0;
                  rd_left <= used_entries - num_t'(1);
                  rd_ptr  <= idx_t'(used_entries > num_t'(1));
                  state   <= S_SCAN;
                end
              end
              OP_POP: begin
                if (used_entries == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  state <= S_POPQ;
                end
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end

        S_SCAN, S_RANK: begin
          if (rd_left != '0) begin
            q_vld   <= 1'b1;
            q_idx   <= rd_ptr;
            rd_left <= rd_left - num_t'(1);
            if (rd_left != num_t'(1)) begin
              rd_ptr <= rd_ptr_inc;
            end
          end else begin
            q_vld <= 1'b0;
          end
          if (state == S_SCAN) begin
            if (q_vld && q_value == val_r) begin
              at_r    <= q_idx;
              cnt_r   <= q_count_inc;
              rd_ptr  <= '0;
              rd_left <= used_entries;
              q_vld   <= 1'b0;
              state   <= S_RANK;
            end else if (q_vld && q_last) begin
              res_status <= ST_MISS;
              state      <= S_EMIT;
            end
          end else if (rank_take || (q_vld && q_last)) begin
            j_r   <= rank_j;
            q_vld <= 1'b0;
            state <= S_MOVE;
            if (rank_j < at_r) begin
              // Entries j..at-1 move one place toward the back.
              mv_dn   <= 1'b0;
              rd_ptr  <= at_r - idx_t'(1);
              wr_ptr  <= at_r;
              rd_left <= num_t'(at_r - rank_j);
            end else begin
              // Entries at+1..j move one place toward the front.
              mv_dn   <= 1'b1;
              rd_ptr  <= (rank_j == at_r) ? at_r : at_r + idx_t'(1);
              wr_ptr  <= at_r;
              rd_left <= num_t'(rank_j - at_r);
            end
          end
        end

        S_MOVE: begin
          if (rd_left != '0) begin
            q_vld   <= 1'b1;
            rd_left <= rd_left - num_t'(1);
            if (rd_left != num_t'(1)) begin
              rd_ptr <= mv_dn ? rd_ptr_inc : rd_ptr_dec;
            end
          end else begin
            q_vld <= 1'b0;
          end
          if (q_vld) begin
            wr_ptr <= mv_dn ? wr_ptr + idx_t'(1) : wr_ptr - idx_t'(1);
          end
          if (rd_left == '0 && !q_vld) begin
            if (op_r == OP_POP) begin
              used_entries <= used_entries - num_t'(1);
              state        <= S_EMIT;
            end else begin
              state <= S_PUT;
            end
          end
        end

        S_PUT: begin
          res_old <= at_r;
          res_new <= j_r;
          res_cnt <= cnt_r;
          state   <= S_EMIT;
        end

        S_POPQ: begin
          res_pop <= q_value;
          mv_dn   <= 1'b1;
          wr_ptr  <= '0;
          rd_ptr  <= idx_t'(1);
          rd_left <= used_entries - num_t'(1);
          q_vld   <= 1'b0;
          state   <= S_MOVE;
        end

        S_EMIT: begin
          rd_ptr <= '0;
          q_vld  <= 1'b0;
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            status       <= res_status;
            old_position <= POS_W'(res_old);
            new_position <= POS_W'(res_new);
            access_count <= ACC_W'(res_cnt);
            popped_value <= res_pop;
            entry_count  <= ENT_W'(used_entries);
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/cosl_checker.sv
`default_nettype none
`include "count_ordered_self_organizing_list_defines.svh"

module cosl_checker
  import cosl_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      item_valid,
  input wire logic                      item_ready,
  input wire logic                      result_valid,
  input wire logic                      result_ready,
  input wire status_t                   status,
  input wire logic [POS_W-1:0]          old_position,
  input wire logic [POS_W-1:0]          new_position,
  input wire logic [ACC_W-1:0]          access_count,
  input wire logic signed [VALUE_W-1:0] popped_value,
  input wire logic [ENT_W-1:0]          entry_count
);

  logic                     in_beat;
  logic                     full_beat;
  logic                     empty_beat;
  logic                     miss_beat;
  logic                     res_stall;
  logic                     empty_clean;
  logic                     miss_clean;
  logic [ENT_W+VALUE_W-1:0] res_tail;

  assign in_beat     = item_valid && item_ready;
  assign full_beat   = result_valid && (status == ST_FULL);
  assign empty_beat  = result_valid && (status == ST_EMPTY);
  assign miss_beat   = result_valid && (status == ST_MISS);
  assign res_stall   = result_valid && !result_ready;
  assign empty_clean = (entry_count == '0) && (popped_value == '0);
  assign miss_clean  = (old_position == '0) && (new_position == '0) && (access_count == '0);
  assign res_tail    = {entry_count, popped_value};

  // The block works on one beat at a time, so it is busy right after an accept.
  `COSL_CHECK_NEXT(a_busy_after_accept, clk, rst, in_beat, !item_ready)

  // A full list reports exactly DEPTH entries.
  `COSL_CHECK_NOW(a_full_count, clk, rst, full_beat, entry_count == ENT_W'(DEPTH))

  // An empty pop reports no entries and no value.
  `COSL_CHECK_NOW(a_empty_pop, clk, rst, empty_beat, empty_clean)

  // A miss carries no positions and no count.
  `COSL_CHECK_NOW(a_miss_clean, clk, rst, miss_beat, miss_clean)

  // A stalled result beat keeps its payload.
  `COSL_CHECK_NEXT(a_result_hold, clk, rst, res_stall, result_valid && $stable(res_tail))

endmodule

bind count_ordered_self_organizing_list cosl_checker #(.DEPTH(DEPTH)) u_cosl_checker (.*);

`default_nettype wire
